### rtl/orcp_pkg.sv
// Package: shared types, constants and tables for the orbit rig camera position unit
package orcp_pkg;

    localparam int unsigned CordicStepsDefault = 16;
    localparam int unsigned AtanEntries        = 24;
    localparam logic signed [31:0] GainQ30     = 32'sd652032874;
    localparam logic signed [16:0] PitchOne    = 17'sd16384;

    typedef enum logic [2:0] {
        REG_PIVOT_X   = 3'd0,
        REG_PIVOT_Y   = 3'd1,
        REG_PIVOT_Z   = 3'd2,
        REG_UPPER_H   = 3'd3,
        REG_LOWER_H   = 3'd4,
        REG_UPPER_R   = 3'd5,
        REG_MIDDLE_R  = 3'd6,
        REG_LOWER_R   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] yaw_turn;
        logic signed [15:0] pitch_frac;
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [31:0] player_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic signed [31:0] camera_z;
    } t_out_item;

    // Data carried along the CORDIC chain alongside the rotation state
    typedef struct packed {
        logic               flip;
        logic signed [16:0] s;
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic signed [33:0] pz;
    } t_side;

    typedef struct packed {
        logic               vld;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        t_side              side;
    } t_cell;

    function automatic logic signed [32:0] atan_lut(input int unsigned i);
        logic signed [32:0] v;
        case (i)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            default: v = 33'sd81;
        endcase
        return v;
    endfunction

endpackage

### rtl/orcp_cordic_cell.sv
// One CORDIC micro-rotation cell of the chain
module orcp_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  orcp_pkg::t_cell  i_cell,
    output orcp_pkg::t_cell  o_cell
);
    import orcp_pkg::*;

    localparam logic signed [32:0] Atan = atan_lut(STEP);

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = i_cell;
        if (i_cell.z >= 0) begin
            n_cell.x = i_cell.x - (i_cell.y >>> STEP);
            n_cell.y = i_cell.y + (i_cell.x >>> STEP);
            n_cell.z = i_cell.z - Atan;
        end else begin
            n_cell.x = i_cell.x + (i_cell.y >>> STEP);
            n_cell.y = i_cell.y - (i_cell.x >>> STEP);
            n_cell.z = i_cell.z + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.x    <= n_cell.x;
            r_cell.y    <= n_cell.y;
            r_cell.z    <= n_cell.z;
            r_cell.side <= n_cell.side;
        end
    end

    assign o_cell = r_cell;
endmodule

### rtl/orcp_blend.sv
// Radius scaling, Bezier blend and saturation pipeline
module orcp_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  orcp_pkg::t_cell     i_cell,
    input  logic signed [31:0]  i_upper_h,
    input  logic signed [31:0]  i_lower_h,
    input  logic [30:0]         i_upper_r,
    input  logic [30:0]         i_middle_r,
    input  logic [30:0]         i_lower_r,
    output logic                o_vld,
    output orcp_pkg::t_out_item o_item
);
    import orcp_pkg::*;

    // stage A: signed cos/sin, u and s
    logic               r_a_vld;
    logic signed [32:0] r_a_c, r_a_s;
    logic signed [17:0] r_a_u, r_a_sv;
    logic signed [33:0] r_a_px, r_a_py, r_a_pz;
    // stage B: r*trig products and weights
    logic               r_b_vld;
    logic signed [64:0] r_b_m [6];
    logic signed [35:0] r_b_w [3];
    logic signed [33:0] r_b_px, r_b_py, r_b_pz;
    // stage C: rounded point offsets
    logic               r_c_vld;
    logic signed [34:0] r_c_p [6];
    logic signed [35:0] r_c_w [3];
    logic signed [33:0] r_c_px, r_c_py, r_c_pz;
    // stage D: weighted terms
    logic               r_d_vld;
    logic signed [71:0] r_d_t [9];
    logic signed [33:0] r_d_px, r_d_py, r_d_pz;
    // stage E: rounded offsets added to player position plus pivot
    logic               r_e_vld;
    logic signed [45:0] r_e_sum [3];

    logic signed [31:0] rad [3];
    logic signed [73:0] acc [3];
    logic signed [73:0] rnd [3];
    logic signed [31:0] sat [3];

    assign rad[0] = {1'b0, i_upper_r};
    assign rad[1] = {1'b0, i_middle_r};
    assign rad[2] = {1'b0, i_lower_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_cell.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
        if (i_en) begin
            r_a_c  <= i_cell.side.flip ? -i_cell.x : i_cell.x;
            r_a_s  <= i_cell.side.flip ? -i_cell.y : i_cell.y;
            r_a_sv <= 18'(i_cell.side.s);
            r_a_u  <= 18'sd32768 - 18'(i_cell.side.s);
            r_a_px <= i_cell.side.px;
            r_a_py <= i_cell.side.py;
            r_a_pz <= i_cell.side.pz;

            for (int k = 0; k < 3; k++) begin
                r_b_m[k]   <= 65'(rad[k] * r_a_c);
                r_b_m[k+3] <= 65'(rad[k] * r_a_s);
            end
            r_b_w[0] <= 36'(r_a_u * r_a_u);
            r_b_w[1] <= 36'(2 * r_a_u * r_a_sv);
            r_b_w[2] <= 36'(r_a_sv * r_a_sv);
            r_b_px <= r_a_px;
            r_b_py <= r_a_py;
            r_b_pz <= r_a_pz;

            for (int k = 0; k < 6; k++) begin
                r_c_p[k] <= 35'((r_b_m[k] + 65'sd536870912) >>> 30);
            end
            r_c_w  <= r_b_w;
            r_c_px <= r_b_px;
            r_c_py <= r_b_py;
            r_c_pz <= r_b_pz;

            for (int k = 0; k < 3; k++) begin
                r_d_t[k]   <= 72'(r_c_p[k] * r_c_w[k]);
                r_d_t[k+3] <= 72'(r_c_p[k+3] * r_c_w[k]);
            end
            r_d_t[6] <= 72'(i_upper_h * r_c_w[0]);
            r_d_t[7] <= 72'sd0;
            r_d_t[8] <= 72'(i_lower_h * r_c_w[2]);
            r_d_px <= r_c_px;
            r_d_py <= r_c_py;
            r_d_pz <= r_c_pz;

            r_e_sum[0] <= 46'(rnd[0]) + 46'(r_d_px);
            r_e_sum[1] <= 46'(rnd[2]) + 46'(r_d_py);
            r_e_sum[2] <= 46'(rnd[1]) + 46'(r_d_pz);
        end
    end

    always_comb begin
        acc[0] = 74'(r_d_t[0]) + 74'(r_d_t[1]) + 74'(r_d_t[2]);
        acc[1] = 74'(r_d_t[3]) + 74'(r_d_t[4]) + 74'(r_d_t[5]);
        acc[2] = 74'(r_d_t[6]) + 74'(r_d_t[7]) + 74'(r_d_t[8]);
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (acc[k] + 74'sd536870912) >>> 30;
        end
        for (int k = 0; k < 3; k++) begin
            if (r_e_sum[k] > 46'sd2147483647) begin
                sat[k] = 32'sh7FFFFFFF;
            end else if (r_e_sum[k] < -46'sd2147483648) begin
                sat[k] = 32'sh80000000;
            end else begin
                sat[k] = r_e_sum[k][31:0];
            end
        end
    end

    assign o_vld           = r_e_vld;
    assign o_item.camera_x = sat[0];
    assign o_item.camera_y = sat[1];
    assign o_item.camera_z = sat[2];
endmodule

### rtl/orbit_rig_camera_position_unit.sv
// Top level: orbit rig camera position unit, CORDIC cell chain and blend pipeline
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | t_in_item
//  out     | output    | o_valid / i_stall  | t_out_item
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// One item per cycle while o_stall is low; an item passes through the cell chain
// (CORDIC_STEPS cells, capped at AtanEntries), the five multiply and blend stages
// and the output register. Synchronous active-low reset clears all valid bits and
// the configuration registers. The whole pipe advances when the output register is
// empty or taken; o_stall follows i_stall while a result is held.
module orbit_rig_camera_position_unit #(
    parameter int unsigned CORDIC_STEPS = orcp_pkg::CordicStepsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  orcp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output orcp_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import orcp_pkg::*;

    localparam int unsigned Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

    logic signed [31:0] r_off_x, r_off_y, r_off_z, r_up_h, r_lo_h;
    logic [30:0]        r_up_r, r_mid_r, r_lo_r;

    logic               en;
    t_cell              chain [Steps+1];
    logic               b_vld;
    t_out_item          b_item;
    logic               r_out_vld;
    t_out_item          r_out;
    logic [31:0]        ang;
    logic signed [16:0] pitch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0; r_off_y <= '0; r_off_z <= '0;
            r_up_h  <= '0; r_lo_h  <= '0;
            r_up_r  <= '0; r_mid_r <= '0; r_lo_r <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PIVOT_X:  r_off_x <= i_cfg_data;
                REG_PIVOT_Y:  r_off_y <= i_cfg_data;
                REG_PIVOT_Z:  r_off_z <= i_cfg_data;
                REG_UPPER_H:  r_up_h  <= i_cfg_data;
                REG_LOWER_H:  r_lo_h  <= i_cfg_data;
                REG_UPPER_R:  r_up_r  <= i_cfg_data[30:0];
                REG_MIDDLE_R: r_mid_r <= i_cfg_data[30:0];
                REG_LOWER_R:  r_lo_r  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    always_comb begin
        ang = {i_item.yaw_turn, 16'h0000};
        if (i_item.yaw_turn[15] ^ i_item.yaw_turn[14]) begin
            ang = ang + 32'h80000000;
        end
        if (i_item.pitch_frac > 16'sd16384) begin
            pitch = PitchOne;
        end else if (i_item.pitch_frac < -16'sd16384) begin
            pitch = -PitchOne;
        end else begin
            pitch = 17'(i_item.pitch_frac);
        end
        chain[0].vld       = i_valid;
        chain[0].x         = 33'(GainQ30);
        chain[0].y         = '0;
        chain[0].z         = 33'(signed'(ang));
        chain[0].side.flip = i_item.yaw_turn[15] ^ i_item.yaw_turn[14];
        chain[0].side.s    = PitchOne - pitch;
        chain[0].side.px   = 34'(i_item.player_x) + 34'(r_off_x);
        chain[0].side.py   = 34'(i_item.player_y) + 34'(r_off_y);
        chain[0].side.pz   = 34'(i_item.player_z) + 34'(r_off_z);
    end

    for (genvar g = 0; g < Steps; g++) begin : g_cell
        orcp_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    orcp_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_cell     (chain[Steps]),
        .i_upper_h  (r_up_h),
        .i_lower_h  (r_lo_h),
        .i_upper_r  (r_up_r),
        .i_middle_r (r_mid_r),
        .i_lower_r  (r_lo_r),
        .o_vld      (b_vld),
        .o_item     (b_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= b_vld;
        end
        if (en) begin
            r_out <= b_item;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld && $stable(r_out))
        else $error("result lost under stall");
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_vld && i_stall)
        else $error("input stalled without a held result");
    a_cell_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(chain[Steps].vld))
        else $error("chain moved while stalled");
endmodule
